// ===== rtl/llcp_ptd_pkg.sv =====
// Shared types, record type codes and constants for the LLCP parameter decoder.
`timescale 1ns / 1ps

package llcp_ptd_pkg;

   // Record type codes
   localparam logic [7:0] T_VERSION = 8'd1;
   localparam logic [7:0] T_MIUX    = 8'd2;
   localparam logic [7:0] T_WKS     = 8'd3;
   localparam logic [7:0] T_LTO     = 8'd4;
   localparam logic [7:0] T_RW      = 8'd5;
   localparam logic [7:0] T_SN      = 8'd6;
   localparam logic [7:0] T_OPT     = 8'd7;
   localparam logic [7:0] T_SDREQ   = 8'd8;
   localparam logic [7:0] T_SDRES   = 8'd9;
   localparam logic [7:0] T_NONE    = 8'd0;

   localparam logic [15:0] MIU_BASE       = 16'd128;
   localparam logic [15:0] LTO_DEFAULT_MS = 16'd100;
   localparam logic [15:0] LTO_UNIT_MS    = 16'd10;
   localparam logic [10:0] MIUX_MASK      = 11'h7ff;
   localparam logic [3:0]  RW_MASK        = 4'hf;
   localparam logic [5:0]  SAP_MASK       = 6'h3f;

   // Command queue between front and back end
   localparam int QDEPTH = 4;

   typedef enum logic [1:0] {
      KIND_PARAM = 2'd0,
      KIND_STR   = 2'd1,
      KIND_END   = 2'd2
   } llcp_kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } llcp_req_type;

   typedef struct packed {
      llcp_kind_type kind;
      logic [7:0]    param_type;
      logic [15:0]   value;
      logic [7:0]    tid;
      logic [5:0]    sap;
      logic [7:0]    str_len;
      logic [7:0]    str_byte;
      logic          dropped;
      logic          last_of_run;
   } llcp_rsp_type;

   // One classified input byte: which results it causes and the data they need
   typedef struct packed {
      logic       ev_str;
      logic       ev_fin;
      logic       ev_end;
      logic [7:0] rec_type;
      logic [7:0] rec_len;
      logic [7:0] v0;
      logic [7:0] cur;
      logic [7:0] end_type;
      logic       drop;
   } llcp_cmd_type;

endpackage

// ===== rtl/llcp_ptd_front.sv =====
// Front end: accepts buffer bytes, tracks the record parse and classifies each byte.
`timescale 1ns / 1ps

module llcp_ptd_front
   import llcp_ptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  llcp_req_type req_data,
   output logic         req_ready,
   output logic         push_valid,
   output llcp_cmd_type push_data,
   input  logic         push_ready
);

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_VAL  = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in, phase_nx;
   logic [7:0] rec_type_ff, rec_type_in, rec_type_nx;
   logic [7:0] rec_len_ff, rec_len_in, rec_len_nx;
   logic [7:0] seen_ff, seen_in, seen_nx;
   logic [7:0] first_ff, first_in, first_nx;
   logic [7:0] seen_inc;
   logic       fin, str, cut, take;
   logic       fin_ok;
   llcp_cmd_type cmd;

   assign take     = req_valid && req_ready;
   assign req_ready = push_ready;
   assign seen_inc = seen_ff + 8'd1;

   // Does a completed record produce a decoded result?
   always_comb begin
      case (rec_type_nx)
         T_VERSION, T_LTO, T_RW, T_OPT: fin_ok = (rec_len_nx == 8'd1);
         T_MIUX, T_WKS, T_SDRES:        fin_ok = (rec_len_nx == 8'd2);
         T_SN:                          fin_ok = 1'b1;
         T_SDREQ:                       fin_ok = (rec_len_nx != 8'd0);
         default:                       fin_ok = 1'b0;
      endcase
   end

   always_comb begin
      phase_nx    = phase_ff;
      rec_type_nx = rec_type_ff;
      rec_len_nx  = rec_len_ff;
      seen_nx     = seen_ff;
      first_nx    = first_ff;
      fin         = 1'b0;
      str         = 1'b0;
      case (phase_ff)
         PH_LEN: begin
            rec_len_nx = req_data.data_byte;
            seen_nx    = 8'd0;
            if (req_data.data_byte == 8'd0) begin
               fin      = 1'b1;
               phase_nx = PH_TYPE;
            end else begin
               phase_nx = PH_VAL;
            end
         end
         PH_VAL: begin
            if (seen_ff == 8'd0) first_nx = req_data.data_byte;
            str     = (rec_type_ff == T_SN) ||
                      ((rec_type_ff == T_SDREQ) && (seen_ff != 8'd0));
            seen_nx = seen_inc;
            if (seen_inc == rec_len_ff) begin
               fin      = 1'b1;
               phase_nx = PH_TYPE;
            end
         end
         default: begin
            rec_type_nx = req_data.data_byte;
            rec_len_nx  = 8'd0;
            seen_nx     = 8'd0;
            first_nx    = 8'd0;
            phase_nx    = PH_LEN;
         end
      endcase

      cut = (phase_nx != PH_TYPE);

      cmd.ev_str   = str;
      cmd.ev_fin   = fin && fin_ok;
      cmd.ev_end   = req_data.last_byte;
      cmd.rec_type = rec_type_nx;
      cmd.rec_len  = rec_len_nx;
      cmd.v0       = first_nx;
      cmd.cur      = (phase_ff == PH_LEN) ? 8'd0 : req_data.data_byte;
      cmd.end_type = cut ? rec_type_nx : T_NONE;
      cmd.drop     = (phase_nx == PH_VAL) &&
                     ((rec_type_nx == T_SN) || (rec_type_nx == T_SDREQ));

      // The last byte closes the buffer: drop back to the reset state
      if (req_data.last_byte) begin
         phase_in    = PH_TYPE;
         rec_type_in = 8'd0;
         rec_len_in  = 8'd0;
         seen_in     = 8'd0;
         first_in    = 8'd0;
      end else begin
         phase_in    = phase_nx;
         rec_type_in = rec_type_nx;
         rec_len_in  = rec_len_nx;
         seen_in     = seen_nx;
         first_in    = first_nx;
      end
   end

   // Push only bytes that cause at least one result
   assign push_valid = req_valid && (cmd.ev_str || cmd.ev_fin || cmd.ev_end);
   assign push_data  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         rec_type_ff <= 8'd0;
         rec_len_ff  <= 8'd0;
         seen_ff     <= 8'd0;
         first_ff    <= 8'd0;
      end else if (take) begin
         phase_ff    <= phase_in;
         rec_type_ff <= rec_type_in;
         rec_len_ff  <= rec_len_in;
         seen_ff     <= seen_in;
         first_ff    <= first_in;
      end
   end

endmodule

// ===== rtl/llcp_ptd_queue.sv =====
// Short command queue between front and back end.
`timescale 1ns / 1ps

module llcp_ptd_queue
   import llcp_ptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_valid,
   input  llcp_cmd_type wr_data,
   output logic         wr_ready,
   output logic         rd_valid,
   output llcp_cmd_type rd_data,
   input  logic         rd_ready
);

   localparam int PW = $clog2(QDEPTH);
   localparam int CW = $clog2(QDEPTH + 1);

   llcp_cmd_type      slot_ff [QDEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_wr, do_rd;

   assign wr_ready = (count_ff != CW'(QDEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) slot_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/llcp_ptd_back.sv =====
// Back end: expands each command into its results and drives the output register.
`timescale 1ns / 1ps

module llcp_ptd_back
   import llcp_ptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  llcp_cmd_type cmd_data,
   output logic         cmd_ready,
   output logic         rsp_valid,
   output llcp_rsp_type rsp_data,
   input  logic         rsp_ready
);

   llcp_cmd_type cmd_ff;
   logic [2:0]   pend_ff, pend_in;   // {end, fin, str}
   logic [2:0]   pick, pend_left;
   logic         rsp_valid_ff, rsp_valid_in;
   llcp_rsp_type rsp_ff, res;
   logic         can_load, emit;
   logic [15:0]  v0_w, lto_ms;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign emit      = can_load && (pend_ff != 3'b000);
   assign pick      = pend_ff & (~pend_ff + 3'd1);
   assign pend_left = emit ? (pend_ff & ~pick) : pend_ff;
   assign cmd_ready = (pend_left == 3'b000);

   assign v0_w   = {8'd0, cmd_ff.v0};
   assign lto_ms = (cmd_ff.v0 == 8'd0) ? LTO_DEFAULT_MS : 16'(v0_w * LTO_UNIT_MS);

   always_comb begin
      res             = '0;
      res.param_type  = cmd_ff.rec_type;
      res.last_of_run = (pend_left == 3'b000);
      if (pick[0]) begin
         res.kind     = KIND_STR;
         res.str_byte = cmd_ff.cur;
         if (cmd_ff.rec_type == T_SDREQ) begin
            res.tid     = cmd_ff.v0;
            res.str_len = cmd_ff.rec_len - 8'd1;
         end else begin
            res.str_len = cmd_ff.rec_len;
         end
      end else if (pick[1]) begin
         res.kind = KIND_PARAM;
         case (cmd_ff.rec_type)
            T_VERSION, T_OPT: res.value = v0_w;
            T_MIUX:  res.value = {5'd0, {cmd_ff.v0[2:0], cmd_ff.cur} & MIUX_MASK} + MIU_BASE;
            T_WKS:   res.value = {cmd_ff.v0, cmd_ff.cur};
            T_LTO:   res.value = lto_ms;
            T_RW:    res.value = {12'd0, cmd_ff.v0[3:0] & RW_MASK};
            T_SN:    res.str_len = cmd_ff.rec_len;
            T_SDREQ: begin
               res.tid     = cmd_ff.v0;
               res.str_len = cmd_ff.rec_len - 8'd1;
            end
            T_SDRES: begin
               res.tid = cmd_ff.v0;
               res.sap = cmd_ff.cur[5:0] & SAP_MASK;
            end
            default: res.value = 16'd0;
         endcase
      end else begin
         res.kind       = KIND_END;
         res.param_type = cmd_ff.end_type;
         res.dropped    = cmd_ff.drop;
      end
   end

   always_comb begin
      pend_in = pend_left;
      if (cmd_ready && cmd_valid) begin
         pend_in = {cmd_data.ev_end, cmd_data.ev_fin, cmd_data.ev_str};
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 3'b000;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_ready && cmd_valid) cmd_ff <= cmd_data;
      if (emit) rsp_ff <= res;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/llcp_param_tlv_decoder.sv =====
// Top level of the LLCP parameter TLV decoder: front end, command queue, back end.
`timescale 1ns / 1ps
//
//  channel   direction  handshake            payload
//  req_*     in         req_valid/req_ready  llcp_req_type  (data_byte, last_byte)
//  rsp_*     out        rsp_valid/rsp_ready  llcp_rsp_type  (kind ... last_of_run)
//
//  A byte is taken every cycle while the command queue has room (four entries).
//  The back end delivers one result per cycle while rsp_ready allows, so a byte
//  that causes several results holds the back end until all have gone out; bytes causing none never enter the queue.
//  A byte reaches its first result through the queue slot, the back end command register and the output register.
//  Reset is synchronous and clears parse state, queue pointers and output valid.
//  A stalled rsp side fills the queue, then req_ready drops; neither side waits
//  on the other otherwise.

module llcp_param_tlv_decoder
   import llcp_ptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  llcp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output llcp_rsp_type rsp_data
);

   logic         push_valid, push_ready;
   llcp_cmd_type push_data;
   logic         pop_valid, pop_ready;
   llcp_cmd_type pop_data;

   // Classify each byte and advance the record parse
   llcp_ptd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   // Hold classified commands until the back end is free
   llcp_ptd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_data  (push_data),
      .wr_ready (push_ready),
      .rd_valid (pop_valid),
      .rd_data  (pop_data),
      .rd_ready (pop_ready)
   );

   // Expand commands into result transfers
   llcp_ptd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_data  (pop_data),
      .cmd_ready (pop_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_ready (rsp_ready)
   );

`ifndef SYNTHESIS
   // End of buffer is always the final result of its byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_END) |-> rsp_data.last_of_run)
      else $error("end-of-buffer result without last_of_run");

   // Only string bytes carry text
   a_str_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind != KIND_STR) |-> (rsp_data.str_byte == 8'd0))
      else $error("str_byte set on a non-string result");

   // Discard flag appears only on end of buffer
   a_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |-> (rsp_data.kind == KIND_END))
      else $error("dropped set on a non-end result");

   // The input stalls only while the command queue holds a command
   a_queue_flow: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> pop_valid)
      else $error("input stalled with an empty command queue");
`endif

endmodule

// ===== verif/llcp_ptd_checker.sv =====
// Checker for the LLCP parameter decoder: predicts results per byte transfer and compares them.
`timescale 1ns / 1ps

module llcp_ptd_checker
   import llcp_ptd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_ready,
   input  llcp_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_ready,
   input  llcp_rsp_type rsp_data,
   output int           fail_count,
   output int           outstanding
);

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_VAL  = 2'd2
   } parse_phase_type;

   parse_phase_type phase;
   logic [7:0]      rec_type;
   logic [7:0]      rec_len;
   logic [7:0]      bytes_seen;
   logic [7:0]      first_value;

   llcp_rsp_type expected_results[$];
   llcp_rsp_type byte_results[$];
   int           errors = 0;

   function automatic llcp_rsp_type make_result(llcp_kind_type kind, logic [7:0] ptype,
                                                logic [15:0] value, logic [7:0] tid,
                                                logic [5:0] sap, logic [7:0] slen,
                                                logic [7:0] sbyte, logic dropped);
      llcp_rsp_type r;
      r.kind        = kind;
      r.param_type  = ptype;
      r.value       = value;
      r.tid         = tid;
      r.sap         = sap;
      r.str_len     = slen;
      r.str_byte    = sbyte;
      r.dropped     = dropped;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   function automatic string describe(llcp_rsp_type r);
      return $sformatf("kind=%0d type=%0d value=%0d tid=%0d sap=%0d len=%0d byte=%0d drop=%0d last=%0d",
                       r.kind, r.param_type, r.value, r.tid, r.sap, r.str_len, r.str_byte,
                       r.dropped, r.last_of_run);
   endfunction

   task automatic clear_state();
      phase       = PH_TYPE;
      rec_type    = T_NONE;
      rec_len     = 8'd0;
      bytes_seen  = 8'd0;
      first_value = 8'd0;
   endtask

   // Record complete; b is its last value byte (meaningless for a zero length record)
   task automatic complete_record(input logic [7:0] b);
      logic [10:0] miu;
      miu = {first_value[2:0], b} & MIUX_MASK;
      case (rec_type)
         T_VERSION: if (rec_len == 8'd1)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, {8'd0, first_value},
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_MIUX: if (rec_len == 8'd2)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, {5'd0, miu} + MIU_BASE,
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_WKS: if (rec_len == 8'd2)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, {first_value, b},
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_LTO: if (rec_len == 8'd1)
            byte_results.push_back(make_result(KIND_PARAM, rec_type,
                                               (first_value != 8'd0) ?
                                               LTO_UNIT_MS * {8'd0, first_value} :
                                               LTO_DEFAULT_MS,
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_RW: if (rec_len == 8'd1)
            byte_results.push_back(make_result(KIND_PARAM, rec_type,
                                               {12'd0, first_value[3:0] & RW_MASK},
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_SN:
            byte_results.push_back(make_result(KIND_PARAM, rec_type, 16'd0,
                                               8'd0, 6'd0, rec_len, 8'd0, 1'b0));
         T_OPT: if (rec_len == 8'd1)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, {8'd0, first_value},
                                               8'd0, 6'd0, 8'd0, 8'd0, 1'b0));
         T_SDREQ: if (rec_len != 8'd0)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, 16'd0,
                                               first_value, 6'd0, rec_len - 8'd1, 8'd0, 1'b0));
         T_SDRES: if (rec_len == 8'd2)
            byte_results.push_back(make_result(KIND_PARAM, rec_type, 16'd0,
                                               first_value, b[5:0] & SAP_MASK, 8'd0, 8'd0,
                                               1'b0));
         default: ;
      endcase
   endtask

   task automatic decode_byte(input llcp_req_type item);
      llcp_rsp_type tail;
      logic         in_string;
      byte_results.delete();
      case (phase)
         PH_LEN: begin
            rec_len    = item.data_byte;
            bytes_seen = 8'd0;
            if (item.data_byte == 8'd0) begin
               complete_record(8'd0);
               phase = PH_TYPE;
            end else begin
               phase = PH_VAL;
            end
         end
         PH_VAL: begin
            if (bytes_seen == 8'd0)
               first_value = item.data_byte;
            if (rec_type == T_SN)
               byte_results.push_back(make_result(KIND_STR, T_SN, 16'd0, 8'd0, 6'd0,
                                                  rec_len, item.data_byte, 1'b0));
            else if (rec_type == T_SDREQ && bytes_seen != 8'd0)
               byte_results.push_back(make_result(KIND_STR, T_SDREQ, 16'd0, first_value,
                                                  6'd0, rec_len - 8'd1, item.data_byte,
                                                  1'b0));
            bytes_seen = bytes_seen + 8'd1;
            if (bytes_seen == rec_len) begin
               complete_record(item.data_byte);
               phase = PH_TYPE;
            end
         end
         default: begin
            rec_type    = item.data_byte;
            rec_len     = 8'd0;
            bytes_seen  = 8'd0;
            first_value = 8'd0;
            phase       = PH_LEN;
         end
      endcase

      if (item.last_byte) begin
         in_string = (phase == PH_VAL) && (rec_type == T_SN || rec_type == T_SDREQ);
         byte_results.push_back(make_result(KIND_END, (phase != PH_TYPE) ? rec_type : T_NONE,
                                            16'd0, 8'd0, 6'd0, 8'd0, 8'd0, in_string));
         clear_state();
      end

      if (byte_results.size() != 0) begin
         tail = byte_results.pop_back();
         tail.last_of_run = 1'b1;
         byte_results.push_back(tail);
      end
      foreach (byte_results[i])
         expected_results.push_back(byte_results[i]);
   endtask

   always @(posedge clock) begin
      llcp_rsp_type want;
      if (reset) begin
         clear_state();
         expected_results.delete();
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result %s", $realtime, describe(rsp_data));
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data !== want) begin
                  if (errors < 10)
                     $display("%0t: mismatch\n  expected %s\n  actual   %s", $realtime,
                              describe(want), describe(rsp_data));
                  errors++;
               end
            end
         end
      end
      fail_count  <= errors;
      outstanding <= expected_results.size();
   end

endmodule

// ===== verif/llcp_param_tlv_decoder_tb.sv =====
// Testbench top for the LLCP parameter decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module llcp_param_tlv_decoder_tb;
   import llcp_ptd_pkg::*;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   llcp_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   llcp_rsp_type rsp_data;

   int fail_count;
   int outstanding;

   // Percentages of cycles in which the sender holds back and the receiver stalls
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_sent    = 0;

   // Idling phases: none, sender only, receiver only, both
   int idle_by_phase[4]  = '{0, 80, 0, 29};
   int stall_by_phase[4] = '{0, 0, 80, 29};

   // Directed buffer: LTO of zero, MIUX with every bit set, empty service name,
   // SDREQ with TID and one URI byte, SDRES with all-ones bytes, OPT, and a
   // service name cut short by the end of the buffer
   logic [7:0] directed_bytes[23] = '{
      T_LTO,   8'd1, 8'h00,
      T_MIUX,  8'd2, 8'hff, 8'hff,
      T_SN,    8'd0,
      T_SDREQ, 8'd2, 8'h5a, 8'h41,
      T_SDRES, 8'd2, 8'hff, 8'hff,
      T_OPT,   8'd1, 8'h80,
      T_SN,    8'd3, 8'h41
   };

   llcp_param_tlv_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   llcp_ptd_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall at random at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Offer one byte and hold it until its transfer; valid stays high into the
   // next byte unless a gap is drawn, so it is never dropped and raised in one step
   task automatic send_byte(input logic [7:0] data, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: data, last_byte: fin};
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // Build one buffer of records and send it, last byte flagged
   task automatic send_buffer();
      logic [7:0] bytes_q[$];
      logic [7:0] rec_type;
      int         rec_len;
      int         n_val;
      int         r;
      bit         cut;
      cut = 1'b0;
      if ($urandom_range(9) == 0) begin
         // noise: a short run of arbitrary bytes
         repeat ($urandom_range(1, 6))
            bytes_q.push_back(8'($urandom_range(255)));
      end else begin
         for (int i = 0; i < $urandom_range(1, 4) && !cut; i++) begin
            // mostly known types, some type zero and some arbitrary codes
            r = $urandom_range(99);
            if (r < 85)
               rec_type = 8'($urandom_range(1, 9));
            else if (r < 90)
               rec_type = T_NONE;
            else
               rec_type = 8'($urandom_range(255));
            // mostly the exact length, else a short or arbitrary one
            if ($urandom_range(3) != 0) begin
               case (rec_type)
                  T_VERSION, T_LTO, T_RW, T_OPT: rec_len = 1;
                  T_MIUX, T_WKS, T_SDRES:        rec_len = 2;
                  default:                       rec_len = $urandom_range(0, 6);
               endcase
            end else if ($urandom_range(9) < 7) begin
               rec_len = $urandom_range(0, 4);
            end else begin
               rec_len = $urandom_range(255);
            end
            bytes_q.push_back(rec_type);
            bytes_q.push_back(8'(rec_len));
            n_val = rec_len;
            // keep long records short: end the buffer inside them
            if (rec_len > 12) begin
               n_val = $urandom_range(0, 8);
               cut   = 1'b1;
            end
            for (int j = 0; j < n_val; j++) begin
               r = $urandom_range(9);
               bytes_q.push_back((r < 2) ? 8'h00 : (r < 4) ? 8'hff : 8'($urandom_range(255)));
            end
         end
         // now and then, end the buffer part way through
         if (!cut && bytes_q.size() > 1 && $urandom_range(7) == 0)
            repeat ($urandom_range(1, bytes_q.size() - 1))
               void'(bytes_q.pop_back());
      end
      foreach (bytes_q[i])
         send_byte(bytes_q[i], i == bytes_q.size() - 1);
   endtask

   initial begin
      // hold reset, then release it at an edge
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i])
         send_byte(directed_bytes[i], i == $size(directed_bytes) - 1);

      // random buffers, spread over the idling phases
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_by_phase[p];
         rsp_stall_pct = stall_by_phase[p];
         while (bytes_sent < $size(directed_bytes) + (p + 1) * 64)
            send_buffer();
      end
      req_valid <= 1'b0;

      // drain: the checker's count is registered, so step once first
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (fail_count == 0 && outstanding == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run
   initial begin
      #(8 * 200000);
      $display("Verification failed");
      $finish;
   end

endmodule
